// ===== rtl/oant_pkg.sv =====
// Shared types and constants for the open-addressed name table.
// Holds field widths, command/status codes, the sequencer state type and hash ops.
// No dependencies.
package oant_pkg;

	// Transaction field widths
	localparam int CMD_W  = 2;
	localparam int NAME_W = 64;
	localparam int LEN_W  = 4;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 6;
	localparam int HASH_W = 16;

	// Request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_CLEAR  = 2'd2
	} oant_cmd_t;

	// Response status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} oant_status_t;

	// Operations of the shared hash unit
	typedef enum logic {
		HOP_BYTE  = 1'b0,
		HOP_FINAL = 1'b1
	} oant_hash_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MOD,
		S_READ,
		S_CHECK,
		S_DONE
	} oant_state_t;

endpackage

// ===== rtl/oant_req_if.sv =====
// Request channel of the name table: valid/ready handshake plus request fields.
// Depends on oant_pkg for field widths.
interface oant_req_if
	import oant_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [NAME_W-1:0] key_name;
	logic [LEN_W-1:0]  key_length;
	logic [VAL_W-1:0]  method_value;

	modport source (output valid, output cmd, output key_name, output key_length,
		output method_value, input ready);
	modport sink (input valid, input cmd, input key_name, input key_length,
		input method_value, output ready);
endinterface

// ===== rtl/oant_rsp_if.sv =====
// Response channel of the name table: valid/ready handshake plus result fields.
// Depends on oant_pkg for field widths.
interface oant_rsp_if
	import oant_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [VAL_W-1:0]  found_value;
	logic [SLOT_W-1:0] slot_used;
	logic [HASH_W-1:0] name_hash;

	modport source (output valid, output status, output found_value, output slot_used,
		output name_hash, input ready);
	modport sink (input valid, input status, input found_value, input slot_used,
		input name_hash, output ready);
endinterface

// ===== rtl/open_addressed_name_table.sv =====
// Open-addressed name table: top level with sequencer, entry RAM and shared units.
// Depends on oant_pkg, oant_req_if, oant_rsp_if, oant_ram, oant_hash_unit, oant_sub_unit.
//
// Usage:
//   req carries one command per transaction: lookup, insert or clear. rsp returns exactly
//   one result per request. A transaction moves when valid and ready are both high.
//   The block works on one request at a time; req.ready is high only while idle.
//   For lookup and insert the name, after saturation, is hashed, reduced modulo
//   TABLE_SIZE and then probed. When TABLE_SIZE is not a power of two the modulo takes
//   KMAX + 1 compare-subtract steps (KMAX = 16 - clog2(TABLE_SIZE)). Slots are probed
//   one per cycle through the entry RAM read.
//   A clear writes one slot per cycle; an unused command goes straight to its result.
//   The hash unit takes one byte per cycle.
//   After reset the block runs a clearing pass over the RAM before it first raises
//   req.ready.
//   A result sits in an output register until rsp.ready takes it; the block accepts
//   the next request meanwhile and holds its own result until the register frees.
module open_addressed_name_table
	import oant_pkg::*;
#(
	parameter int TABLE_SIZE   = 64,
	parameter int NAME_BYTES   = 8,
	parameter int PROBE_STRIDE = 7,
	parameter int VALUE_BITS   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	oant_req_if.sink  req,
	oant_rsp_if.source rsp
);
	localparam int  IW    = $clog2(TABLE_SIZE);
	localparam int  NW    = 8 * NAME_BYTES;
	localparam int  VB    = VALUE_BITS;
	localparam int  EW    = 1 + LEN_W + NW + VB;
	localparam int  STEP  = PROBE_STRIDE % TABLE_SIZE;
	localparam bit  POW2  = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
	localparam int  KMAX  = HASH_W - $clog2(TABLE_SIZE);
	localparam int  KW    = $clog2(KMAX + 1);
	localparam int  MODW  = HASH_W + 1;

	oant_state_t state_q, state_d;

	// request registers
	logic [CMD_W-1:0]  cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [NW-1:0]     name_q;
	logic [VB-1:0]     val_q;
	logic [NW-1:0]     sh_q;
	logic [LEN_W-1:0]  bcnt_q;
	logic [HASH_W-1:0] h_q;
	logic [HASH_W-1:0] r_q;
	logic [KW-1:0]     k_q;
	logic [IW-1:0]     pos_q;
	logic [IW-1:0]     n_q;
	logic [IW-1:0]     clr_q;
	logic              clr_resp_q;

	// pending result and output register
	logic [STAT_W-1:0] res_status_q;
	logic [VAL_W-1:0]  res_value_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [HASH_W-1:0] res_hash_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [HASH_W-1:0] out_hash_q;

	// input decode
	logic [LEN_W-1:0]   len_sat;
	logic [NW-1:0]      name_in;
	logic [VB+VAL_W-1:0] val_ext;
	logic               accept;

	// RAM ports
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	// shared units
	oant_hash_op_t     hop;
	logic [HASH_W-1:0] hout;
	logic [MODW-1:0]   sub_a, sub_b, sub_d;

	// probe decode
	logic                 e_full;
	logic [LEN_W-1:0]     e_len;
	logic [NW-1:0]        e_name;
	logic [VB-1:0]        e_val;
	logic                 e_match;
	logic                 chk_last;
	logic                 is_lookup;
	logic                 adv;
	logic [IW-1:0]        nxt_pos;
	logic [IW+SLOT_W-1:0] pos_ext;
	logic [VB+VAL_W-1:0]  fv_ext;
	logic                 out_load;

	// saturate length and drop bytes past it
	always_comb begin
		len_sat = (req.key_length > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : req.key_length;
		for (int i = 0; i < NAME_BYTES; i++) begin
			name_in[8*i +: 8] = (LEN_W'(i) < len_sat) ? req.key_name[8*i +: 8] : 8'h00;
		end
	end

	assign val_ext = {{VB{1'b0}}, req.method_value};
	assign accept  = req.valid && req.ready;

	// entry RAM: {full, length, name, value}
	oant_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// hash unit: byte mix while bytes remain, then the final avalanche
	assign hop = (bcnt_q != '0) ? HOP_BYTE : HOP_FINAL;

	oant_hash_unit u_hash (
		.op      (hop),
		.h_in    (h_q),
		.byte_in (sh_q[7:0]),
		.h_out   (hout)
	);

	// compare-subtract unit: modulo steps in S_MOD, probe wrap in S_CHECK
	always_comb begin
		if (state_q == S_CHECK) begin
			sub_a = MODW'(pos_q) + MODW'(STEP);
			sub_b = MODW'(TABLE_SIZE);
		end else begin
			sub_a = {1'b0, r_q};
			sub_b = MODW'(TABLE_SIZE) << k_q;
		end
	end

	oant_sub_unit #(
		.W (MODW)
	) u_sub (
		.a (sub_a),
		.b (sub_b),
		.d (sub_d)
	);

	// probed entry decode
	assign e_val     = ram_rdata[VB-1:0];
	assign e_name    = ram_rdata[VB +: NW];
	assign e_len     = ram_rdata[VB+NW +: LEN_W];
	assign e_full    = ram_rdata[EW-1];
	assign e_match   = (e_len == len_q) && (e_name == name_q);
	assign is_lookup = (cmd_q == CMD_LOOKUP);
	assign chk_last  = (n_q == IW'(TABLE_SIZE - 1));
	assign adv       = e_full && !(is_lookup && e_match) && !chk_last;
	assign nxt_pos   = sub_d[IW-1:0];
	assign pos_ext   = {{SLOT_W{1'b0}}, pos_q};
	assign fv_ext    = {{VAL_W{1'b0}}, e_val};
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// next state and RAM control
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {1'b1, len_q, name_q, val_q};
		ram_raddr = pos_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == IW'(TABLE_SIZE - 1)) begin
					state_d = clr_resp_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (req.cmd)
						CMD_LOOKUP, CMD_INSERT: state_d = S_HASH;
						CMD_CLEAR:              state_d = S_CLEAR;
						default:                state_d = S_DONE;
					endcase
				end
			end
			S_HASH: begin
				if (bcnt_q == '0) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (POW2 || k_q == '0) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				ram_raddr = nxt_pos;
				if (!is_lookup && !e_full) begin
					ram_we = 1'b1;
				end
				if (!adv) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			clr_resp_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
			if (state_q == S_IDLE) begin
				clr_resp_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q        <= req.cmd;
					len_q        <= len_sat;
					name_q       <= name_in;
					val_q        <= val_ext[VB-1:0];
					sh_q         <= name_in;
					bcnt_q       <= len_sat;
					h_q          <= '0;
					res_status_q <= ST_OK;
					res_value_q  <= '0;
					res_slot_q   <= '0;
					res_hash_q   <= '0;
				end
			end
			S_HASH: begin
				if (bcnt_q != '0) begin
					h_q    <= hout;
					sh_q   <= sh_q >> 8;
					bcnt_q <= bcnt_q - 1'b1;
				end else begin
					res_hash_q <= hout;
					r_q        <= hout;
					k_q        <= KW'(KMAX);
				end
			end
			S_MOD: begin
				if (POW2) begin
					pos_q <= r_q[IW-1:0];
					n_q   <= '0;
				end else if (k_q == '0) begin
					pos_q <= sub_d[IW-1:0];
					n_q   <= '0;
				end else begin
					r_q <= sub_d[HASH_W-1:0];
					k_q <= k_q - 1'b1;
				end
			end
			S_CHECK: begin
				if (adv) begin
					pos_q <= nxt_pos;
					n_q   <= n_q + 1'b1;
				end
				if (is_lookup) begin
					if (e_full && e_match) begin
						res_value_q <= fv_ext[VAL_W-1:0];
						res_slot_q  <= pos_ext[SLOT_W-1:0];
					end else if (!e_full || chk_last) begin
						res_status_q <= ST_MISS;
					end
				end else begin
					if (!e_full) begin
						res_slot_q <= pos_ext[SLOT_W-1:0];
					end else if (chk_last) begin
						res_status_q <= ST_FULL;
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					out_status_q <= res_status_q;
					out_value_q  <= res_value_q;
					out_slot_q   <= res_slot_q;
					out_hash_q   <= res_hash_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_value = out_value_q;
	assign rsp.slot_used   = out_slot_q;
	assign rsp.name_hash   = out_hash_q;
endmodule

// ===== rtl/oant_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oant_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/oant_hash_unit.sv =====
// Shared one-at-a-time hash step: either mixes in one name byte or applies the final avalanche.
// Depends on oant_pkg.
module oant_hash_unit
	import oant_pkg::*;
(
	input  oant_hash_op_t     op,
	input  logic [HASH_W-1:0] h_in,
	input  logic [7:0]        byte_in,
	output logic [HASH_W-1:0] h_out
);
	logic [HASH_W-1:0] a, b;

	always_comb begin
		a = '0;
		b = '0;
		unique case (op)
			HOP_BYTE: begin
				a     = h_in + HASH_W'(byte_in);
				b     = a + (a << 10);
				h_out = b ^ (b >> 6);
			end
			HOP_FINAL: begin
				a     = h_in + (h_in << 3);
				b     = a ^ (a >> 11);
				h_out = b + (b << 15);
			end
			default: h_out = '0;
		endcase
	end
endmodule

// ===== rtl/oant_sub_unit.sv =====
// Shared compare-and-subtract unit: d = (a >= b) ? a - b : a.
// Used for the modulo reduction of the hash and for wrapping the probe index. No dependencies.
module oant_sub_unit #(
	parameter int W = 17
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] d
);
	assign d = (a >= b) ? (a - b) : a;
endmodule

// ===== tb/sv/oant_table_checker.sv =====
// Checker for the open-addressed name table: watches both channels, keeps a shadow copy
// of the table, predicts each result and compares it field by field.
// Depends on oant_pkg, oant_req_if and oant_rsp_if.
`timescale 1ns / 1ps
module oant_table_checker
	import oant_pkg::*;
#(
	parameter int TABLE_SIZE   = 64,
	parameter int NAME_BYTES   = 8,
	parameter int PROBE_STRIDE = 7
) (
	input  logic clk,
	input  logic arst_n,
	oant_req_if  req,
	oant_rsp_if  rsp,
	output int   errors,
	output int   outstanding
);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value;
		logic [SLOT_W-1:0] slot;
		logic [HASH_W-1:0] hash;
	} table_reply_t;

	// Shadow table; name/length/value are only read from occupied slots
	logic [TABLE_SIZE-1:0] shadow_full = '0;
	logic [NAME_W-1:0]     shadow_name [TABLE_SIZE];
	logic [LEN_W-1:0]      shadow_len  [TABLE_SIZE];
	logic [VAL_W-1:0]      shadow_value[TABLE_SIZE];

	table_reply_t replies_due[$];
	table_reply_t want;

	// 16-bit one-at-a-time hash over the first nb bytes
	function automatic logic [HASH_W-1:0] name_digest(input logic [NAME_W-1:0] name,
		input int unsigned nb);
		logic [HASH_W-1:0] h;
		h = '0;
		for (int i = 0; i < nb; i++) begin
			h = h + HASH_W'(name[8*i +: 8]);
			h = h + (h << 10);
			h = h ^ (h >> 6);
		end
		h = h + (h << 3);
		h = h ^ (h >> 11);
		h = h + (h << 15);
		return h;
	endfunction

	// Apply one request to the shadow table and return the result it should give
	function automatic table_reply_t predict_reply(input logic [CMD_W-1:0] op,
		input logic [NAME_W-1:0] key, input logic [LEN_W-1:0] klen,
		input logic [VAL_W-1:0] val);
		table_reply_t      r;
		int unsigned       nb;
		int unsigned       pos;
		logic [NAME_W-1:0] name;
		logic              done;
		r = '0;
		if (op == CMD_CLEAR) begin
			shadow_full = '0;
			return r;
		end
		// unused command: no effect, all-zero result
		if (op != CMD_LOOKUP && op != CMD_INSERT)
			return r;
		// overlong names saturate; bytes past the length do not take part
		nb   = (klen > NAME_BYTES) ? NAME_BYTES : klen;
		name = (nb >= 8) ? key : key & ((64'd1 << (8 * nb)) - 64'd1);
		r.hash = name_digest(name, nb);
		pos  = r.hash % TABLE_SIZE;
		done = 1'b0;
		if (op == CMD_INSERT) begin
			r.status = ST_FULL;
			for (int n = 0; n < TABLE_SIZE && !done; n++) begin
				if (!shadow_full[pos]) begin
					shadow_full[pos]  = 1'b1;
					shadow_name[pos]  = name;
					shadow_len[pos]   = LEN_W'(nb);
					shadow_value[pos] = val;
					r.status = ST_OK;
					r.slot   = pos[SLOT_W-1:0];
					done     = 1'b1;
				end else
					pos = (pos + PROBE_STRIDE) % TABLE_SIZE;
			end
		end else begin
			// lookup: stop at a match, at an empty slot or after a full cycle of probes
			r.status = ST_MISS;
			for (int n = 0; n < TABLE_SIZE && !done; n++) begin
				if (!shadow_full[pos])
					done = 1'b1;
				else if (shadow_len[pos] == nb && shadow_name[pos] == name) begin
					r.status = ST_OK;
					r.value  = shadow_value[pos];
					r.slot   = pos[SLOT_W-1:0];
					done     = 1'b1;
				end else
					pos = (pos + PROBE_STRIDE) % TABLE_SIZE;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string field, input logic [VAL_W-1:0] exp_v,
		input logic [VAL_W-1:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
		end
	endtask

	// Result side first: a result accepted at this edge always belongs to an older request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_full = '0;
			replies_due.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display({"%0t: result transaction, expected none, ",
						"got status %0d value %0h slot %0d hash %0h"},
						$time, rsp.status, rsp.found_value, rsp.slot_used, rsp.name_hash);
				end else begin
					want = replies_due.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("found_value", want.value, rsp.found_value);
					check_field("slot_used", want.slot, rsp.slot_used);
					check_field("name_hash", want.hash, rsp.name_hash);
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(predict_reply(req.cmd, req.key_name, req.key_length,
					req.method_value));
			outstanding <= replies_due.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the open-addressed name table: clock, reset, request stimulus,
// result-side backpressure and the verdict.
// Depends on oant_pkg, oant_req_if, oant_rsp_if, the block and oant_table_checker.
`timescale 1ns / 1ps
module tb;
	import oant_pkg::*;

	localparam int               TABLE_SIZE   = 64;
	localparam int               NAME_BYTES   = 8;
	localparam int               ITEMS        = 850;
	localparam int               HOLD_CYCLES  = 400;
	localparam int               DRAIN_CYCLES = 100;
	localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   sent;        // accepted request transactions
	int   work_items;  // accepted requests other than the unused command
	bit   steady;      // both sides stop idling while set

	// Names offered for insert since the last clear, for lookups and repeat inserts
	logic [NAME_W-1:0] pool_name[$];
	logic [LEN_W-1:0]  pool_len[$];

	oant_req_if req_ch ();
	oant_rsp_if rsp_ch ();

	open_addressed_name_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	oant_table_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic logic [NAME_W-1:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	// Mostly valid lengths, some empty and some overlong
	function automatic logic [LEN_W-1:0] rand_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 15)
			return LEN_W'($urandom_range(15, NAME_BYTES + 1));
		return LEN_W'($urandom_range(NAME_BYTES, 1));
	endfunction

	// Offer one request transaction and wait until it is taken
	task automatic issue(input logic [CMD_W-1:0] op, input logic [NAME_W-1:0] key,
		input logic [LEN_W-1:0] klen, input logic [VAL_W-1:0] val);
		while (!steady && $urandom_range(99) < 15) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= op;
		req_ch.key_name     <= key;
		req_ch.key_length   <= klen;
		req_ch.method_value <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		steady = (sent >= 400 && sent < 520);
		if (op != CMD_UNUSED)
			work_items++;
		if (op == CMD_CLEAR) begin
			pool_name.delete();
			pool_len.delete();
		end else if (op == CMD_INSERT) begin
			pool_name.push_back(key);
			pool_len.push_back(klen);
		end
	endtask

	// A stored name with fresh garbage past its length; overlong lengths vary
	task automatic pick_known(output logic [NAME_W-1:0] key, output logic [LEN_W-1:0] klen);
		int unsigned       idx;
		int unsigned       nb;
		logic [NAME_W-1:0] keep;
		idx  = $urandom_range(pool_name.size() - 1);
		klen = pool_len[idx];
		nb   = (klen > NAME_BYTES) ? NAME_BYTES : klen;
		if (nb == NAME_BYTES)
			klen = LEN_W'($urandom_range(15, NAME_BYTES));
		keep = (nb == NAME_BYTES) ? '1 : (64'd1 << (8 * nb)) - 64'd1;
		key  = (pool_name[idx] & keep) | (wide_random() & ~keep);
	endtask

	// Mixed inserts and lookups, with some unused commands and clears, on a table that starts empty
	task automatic workload_episode(input int count);
		logic [NAME_W-1:0] key;
		logic [LEN_W-1:0]  klen;
		int unsigned       r;
		issue(CMD_CLEAR, wide_random(), rand_len(), $urandom);
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 40)
				issue(CMD_INSERT, wide_random(), rand_len(), $urandom);
			else if (r < 47 && pool_name.size() > 0) begin
				pick_known(key, klen);
				issue(CMD_INSERT, key, klen, $urandom);
			end else if (r < 85 && pool_name.size() > 0) begin
				pick_known(key, klen);
				issue(CMD_LOOKUP, key, klen, $urandom);
			end else if (r < 96)
				issue(CMD_LOOKUP, wide_random(), rand_len(), $urandom);
			else if (r < 98)
				issue(CMD_UNUSED, wide_random(), rand_len(), $urandom);
			else
				issue(CMD_CLEAR, wide_random(), rand_len(), $urandom);
		end
	endtask

	// Fill the table past capacity, then look up on the full table
	task automatic fill_episode();
		logic [NAME_W-1:0] key;
		logic [LEN_W-1:0]  klen;
		issue(CMD_CLEAR, wide_random(), rand_len(), $urandom);
		repeat (TABLE_SIZE + 6)
			issue(CMD_INSERT, wide_random(), rand_len(), $urandom);
		repeat (12) begin
			if ($urandom_range(1)) begin
				pick_known(key, klen);
				issue(CMD_LOOKUP, key, klen, $urandom);
			end else
				issue(CMD_LOOKUP, wide_random(), rand_len(), $urandom);
		end
	endtask

	// Result side: random stalls, one long hold-off to back the block up
	initial begin : result_sink
		bit held;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent >= 250) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else
				rsp_ch.ready <= steady || ($urandom_range(99) >= 15);
		end
	end

	initial begin : stimulus
		int episode;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.cmd          <= CMD_LOOKUP;
		req_ch.key_name     <= '0;
		req_ch.key_length   <= '0;
		req_ch.method_value <= '0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, empty and overlong names, ignored bytes, duplicates,
		// value extremes, unused command, clear
		issue(CMD_LOOKUP, 64'h0000_0000_0063_6261, 4'd3, '0);
		issue(CMD_INSERT, wide_random(), 4'd0, 32'h0000_0000);
		issue(CMD_LOOKUP, wide_random(), 4'd0, '1);
		issue(CMD_INSERT, '1, 4'd8, 32'hFFFF_FFFF);
		issue(CMD_LOOKUP, '1, 4'd15, '0);
		issue(CMD_LOOKUP, '1, 4'd8, '0);
		issue(CMD_INSERT, 64'hDEAD_BEEF_0063_6261, 4'd3, 32'h1234_5678);
		issue(CMD_LOOKUP, 64'hFFFF_FFFF_FF63_6261, 4'd3, '0);
		issue(CMD_LOOKUP, 64'h0000_0000_0063_6261, 4'd2, '0);
		issue(CMD_INSERT, 64'h0000_0000_0063_6261, 4'd3, 32'h8765_4321);
		issue(CMD_LOOKUP, 64'h0000_0000_0063_6261, 4'd3, '0);
		issue(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, 32'hA5A5_A5A5);
		issue(CMD_LOOKUP, 64'h0, 4'd1, '0);
		issue(CMD_LOOKUP, 64'h0, 4'd9, '0);
		issue(CMD_INSERT, 64'h0, 4'd12, 32'h0000_0001);
		issue(CMD_LOOKUP, 64'h0, 4'd8, '0);
		issue(CMD_UNUSED, '1, 4'hF, '1);
		issue(CMD_CLEAR, '1, 4'hF, '1);
		issue(CMD_LOOKUP, 64'h0000_0000_0063_6261, 4'd3, '0);
		issue(CMD_LOOKUP, '1, 4'd8, '0);

		// Random episodes; every fourth one runs the table full
		work_items = 0;
		episode    = 0;
		while (work_items < ITEMS) begin
			if (episode % 4 == 1)
				fill_episode();
			else
				workload_episode($urandom_range(120, 40));
			episode++;
		end
		req_ch.valid <= 1'b0;

		// Drain, then give the block time to show any stray result
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
